[sv/assert_macros.svh]
// Assertion macros used by the top RTL file of the window buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define SBWB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sbwb assertion failed");

// Condition that must never be true.
`define SBWB_ASSERT_NEVER(lbl, clk, rstn, expr) \
  `SBWB_ASSERT(lbl, clk, rstn, !(expr))

`endif

[sv/sbwb_pkg.sv]
package sbwb_pkg;

  // Ring geometry and block number width.
  localparam int RING_DEPTH  = 16;
  localparam int NUMBER_BITS = 56;
  localparam int SLOT_W      = $clog2(RING_DEPTH);
  localparam int CNT_W       = $clog2(RING_DEPTH + 1);

  // Field widths of the request and response beats.
  localparam int OPC_W    = 1;
  localparam int REL_W    = 4;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 4;
  localparam int EVICT_W  = 5;

  // Request opcodes.
  localparam logic [OPC_W-1:0] OP_LOOKUP  = 1'b0;
  localparam logic [OPC_W-1:0] OP_RELEASE = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STALE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [NUMBER_BITS-1:0] num_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic search;
    logic do_release;
    logic do_ignore;
    logic set_hit;
    logic set_stale;
    logic setup_alloc;
    logic alloc_step;
    logic tidy_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_release;
    logic rel_ok;
    logic hit;
    logic stale;
    logic alloc_last;
    logic tidy_done;
    logic out_free;
  } stat_t;

  // Next slot around the ring.
  function automatic slot_t slot_inc(slot_t s);
    if (s == slot_t'(RING_DEPTH - 1)) begin
      return '0;
    end
    return s + slot_t'(1);
  endfunction

  // Slot that lies c places after s around the ring, with c at most RING_DEPTH.
  function automatic slot_t slot_add(slot_t s, cnt_t c);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(s) + (CNT_W + 1)'(c);
    if (sum >= (CNT_W + 1)'(RING_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(RING_DEPTH);
    end
    return slot_t'(sum);
  endfunction

endpackage

[sv/sbwb_ifs.sv]
// Request channel: one lookup or release per beat.
interface sbwb_req_if;
  logic                             valid;
  logic                             ready;
  logic [sbwb_pkg::OPC_W-1:0]       opcode;
  logic [sbwb_pkg::NUMBER_BITS-1:0] block_number;
  logic [sbwb_pkg::REL_W-1:0]       release_slot;

  modport source (output valid, opcode, block_number, release_slot, input ready);
  modport sink   (input valid, opcode, block_number, release_slot, output ready);
endinterface

// Response channel: one result per request beat.
interface sbwb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sbwb_pkg::STATUS_W-1:0] status;
  logic [sbwb_pkg::IDX_W-1:0]    slot_index;
  logic [sbwb_pkg::EVICT_W-1:0]  evicted_count;

  modport source (output valid, status, slot_index, evicted_count, input ready);
  modport sink   (input valid, status, slot_index, evicted_count, output ready);
endinterface

[sv/sbwb_ctrl.sv]
module sbwb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sbwb_pkg::stat_t stat_i,
  output sbwb_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_ALLOC  = 3'd3;
  localparam logic [2:0] S_TIDY   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencing of one request through search, allocation and head cleanup.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat_i.is_release) begin
          if (stat_i.rel_ok) begin
            cmd_o.do_release = 1'b1;
            state_d          = S_TIDY;
          end else begin
            cmd_o.do_ignore = 1'b1;
            state_d         = S_DONE;
          end
        end else begin
          cmd_o.search = 1'b1;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.hit) begin
          cmd_o.set_hit = 1'b1;
          state_d       = S_DONE;
        end else if (stat_i.stale) begin
          cmd_o.set_stale = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.setup_alloc = 1'b1;
          state_d           = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd_o.alloc_step = 1'b1;
        if (stat_i.alloc_last) begin
          state_d = S_TIDY;
        end
      end
      S_TIDY: begin
        if (stat_i.tidy_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.tidy_step = 1'b1;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/sbwb_datapath.sv]
module sbwb_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sbwb_pkg::cmd_t                   cmd_i,
  output sbwb_pkg::stat_t                  stat_o,
  input  logic [sbwb_pkg::OPC_W-1:0]       opcode_i,
  input  logic [sbwb_pkg::NUMBER_BITS-1:0] block_number_i,
  input  logic [sbwb_pkg::REL_W-1:0]       release_slot_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sbwb_pkg::STATUS_W-1:0]    status_o,
  output logic [sbwb_pkg::IDX_W-1:0]       slot_index_o,
  output logic [sbwb_pkg::EVICT_W-1:0]     evicted_count_o
);

  localparam int NB = sbwb_pkg::NUMBER_BITS;
  localparam int RD = sbwb_pkg::RING_DEPTH;

  // Ring state.
  sbwb_pkg::num_t  tag_q [RD];
  logic [RD-1:0]   valid_q;
  sbwb_pkg::slot_t head_q;
  sbwb_pkg::cnt_t  count_q;
  sbwb_pkg::num_t  newest_q;
  logic            known_q;

  // Working registers of the current request.
  logic [sbwb_pkg::OPC_W-1:0]    opcode_q;
  sbwb_pkg::num_t                num_q;
  logic [sbwb_pkg::REL_W-1:0]    rel_q;
  logic [RD-1:0]                 match_q;
  sbwb_pkg::num_t                diff_q;
  logic                          stale_q;
  sbwb_pkg::cnt_t                rem_q;
  sbwb_pkg::slot_t               wptr_q;
  sbwb_pkg::num_t                wtag_q;
  sbwb_pkg::cnt_t                evict_q;
  logic [sbwb_pkg::STATUS_W-1:0] status_q;
  sbwb_pkg::slot_t               slot_q;

  // Output register.
  logic                          out_valid_q;
  logic [sbwb_pkg::STATUS_W-1:0] out_status_q;
  logic [sbwb_pkg::IDX_W-1:0]    out_slot_q;
  logic [sbwb_pkg::EVICT_W-1:0]  out_evict_q;

  logic [RD-1:0]   match_d;
  logic [NB:0]     sub;
  logic            stale_d;
  sbwb_pkg::slot_t hit_idx;
  sbwb_pkg::cnt_t  k;
  sbwb_pkg::num_t  start;
  sbwb_pkg::slot_t tail;
  sbwb_pkg::slot_t rel_slot;
  sbwb_pkg::cnt_t  count_dec;
  logic            full;
  logic            rel_ok;

  // Parallel tag compare over every slot; valid tags are unique.
  always_comb begin
    for (int i = 0; i < RD; i++) begin
      match_d[i] = valid_q[i] && (tag_q[i] == num_q);
    end
  end

  // Distance from the newest number; the borrow marks an older number.
  assign sub     = {1'b0, num_q} - {1'b0, newest_q};
  assign stale_d = known_q && (sub[NB] || (sub[NB-1:0] == '0));

  // Index of the single matching slot.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < RD; i++) begin
      if (match_q[i]) begin
        hit_idx = hit_idx | sbwb_pkg::slot_t'(i);
      end
    end
  end

  // Allocation length, first number and first slot.
  always_comb begin
    if (!known_q) begin
      k = sbwb_pkg::cnt_t'(1);
    end else if (diff_q > sbwb_pkg::num_t'(RD)) begin
      k = sbwb_pkg::cnt_t'(RD);
    end else begin
      k = sbwb_pkg::cnt_t'(diff_q);
    end
  end

  assign start     = num_q - sbwb_pkg::num_t'(k) + sbwb_pkg::num_t'(1);
  assign tail      = sbwb_pkg::slot_add(head_q, count_q);
  assign full      = (count_q == sbwb_pkg::cnt_t'(RD));
  assign count_dec = count_q - sbwb_pkg::cnt_t'(1);
  assign rel_slot  = sbwb_pkg::slot_t'(rel_q);
  assign rel_ok    = (32'(rel_q) < RD) && valid_q[rel_slot];

  // Status toward the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.is_release = (opcode_q == sbwb_pkg::OP_RELEASE);
    stat_o.rel_ok     = rel_ok;
    stat_o.hit        = |match_q;
    stat_o.stale      = stale_q;
    stat_o.alloc_last = (rem_q == sbwb_pkg::cnt_t'(1));
    stat_o.tidy_done  = (count_q == '0) || valid_q[head_q];
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Ring control state: valid bits, head, occupancy, newest number and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      head_q      <= '0;
      count_q     <= '0;
      newest_q    <= '0;
      known_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.do_release) begin
        valid_q[rel_slot] <= 1'b0;
      end
      if (cmd_i.setup_alloc) begin
        newest_q <= num_q;
        known_q  <= 1'b1;
      end
      if (cmd_i.alloc_step) begin
        valid_q[wptr_q] <= 1'b1;
        if (full) begin
          head_q <= sbwb_pkg::slot_inc(head_q);
        end else begin
          count_q <= count_q + sbwb_pkg::cnt_t'(1);
        end
      end
      if (cmd_i.tidy_step) begin
        count_q <= count_dec;
        if (count_dec != '0) begin
          head_q <= sbwb_pkg::slot_inc(head_q);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Tags, working registers and response payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q <= opcode_i;
      num_q    <= block_number_i;
      rel_q    <= release_slot_i;
      slot_q   <= '0;
      evict_q  <= '0;
    end
    if (cmd_i.do_release) begin
      status_q <= sbwb_pkg::ST_RELEASED;
    end
    if (cmd_i.do_ignore) begin
      status_q <= sbwb_pkg::ST_IGNORED;
    end
    if (cmd_i.search) begin
      match_q <= match_d;
      diff_q  <= sub[NB-1:0];
      stale_q <= stale_d;
    end
    if (cmd_i.set_hit) begin
      status_q <= sbwb_pkg::ST_HIT;
      slot_q   <= hit_idx;
    end
    if (cmd_i.set_stale) begin
      status_q <= sbwb_pkg::ST_STALE;
    end
    if (cmd_i.setup_alloc) begin
      status_q <= sbwb_pkg::ST_ALLOC;
      rem_q    <= k;
      wptr_q   <= tail;
      wtag_q   <= start;
    end
    if (cmd_i.alloc_step) begin
      tag_q[wptr_q] <= wtag_q;
      wtag_q        <= wtag_q + sbwb_pkg::num_t'(1);
      wptr_q        <= sbwb_pkg::slot_inc(wptr_q);
      rem_q         <= rem_q - sbwb_pkg::cnt_t'(1);
      slot_q        <= wptr_q;
      if (valid_q[wptr_q]) begin
        evict_q <= evict_q + sbwb_pkg::cnt_t'(1);
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_slot_q   <= sbwb_pkg::IDX_W'(slot_q);
      out_evict_q  <= sbwb_pkg::EVICT_W'(evict_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_index_o    = out_slot_q;
  assign evicted_count_o = out_evict_q;

endmodule

[sv/sliding_block_window_buffer.sv]
// Sliding block window buffer: a ring of 16 slots holding consecutive block
// numbers. A lookup beat returns the slot of a known block, rejects a number at
// or below the newest one as stale, or allocates the missing numbers up to the
// requested one at the tail, evicting and counting valid blocks it overwrites.
// A release beat clears a slot and moves the head past cleared slots. One
// request is handled at a time by a controller stepping a single write port
// and a single head pointer: a lookup is searched and then decided, an
// allocation writes one block per step, and a valid release or an allocation
// then steps the head past the empty slots at the front. Results sit in an
// output register, so a request may be taken while the previous response
// still waits.
`include "assert_macros.svh"

module sliding_block_window_buffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbwb_req_if.sink   in_i,
  sbwb_rsp_if.source out_o
);

  sbwb_pkg::cmd_t  cmd;
  sbwb_pkg::stat_t stat;

  // Request sequencer.
  sbwb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Slot ring, compare logic and response register.
  sbwb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (in_i.opcode),
    .block_number_i  (in_i.block_number),
    .release_slot_i  (in_i.release_slot),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .status_o        (out_o.status),
    .slot_index_o    (out_o.slot_index),
    .evicted_count_o (out_o.evicted_count)
  );

  // A new request is never taken while ring updates are in progress.
  `SBWB_ASSERT_NEVER(a_ready_while_busy, clk_i, rst_ni, in_i.ready && (cmd.alloc_step || cmd.tidy_step))

  // In the cycle after a request beat the block is busy.
  `SBWB_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> !in_i.ready)

  // A response is only loaded when the output register can take it.
  `SBWB_ASSERT(a_load_when_free, clk_i, rst_ni, cmd.load_out |-> (!out_o.valid || out_o.ready))

endmodule

[tb/tb_sliding_block_window_buffer.sv]
module tb_sliding_block_window_buffer;
  import sbwb_pkg::*;

  localparam int   CYCLE_LIMIT   = 400000;
  localparam int   DRAIN_CYCLES  = 64;
  localparam num_t NUM_MAX       = '1;

  // One response beat as the window buffer should return it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot_index;
    logic [EVICT_W-1:0]  evicted;
  } window_reply_t;

  logic clk;
  logic rst_n;

  sbwb_req_if req_if ();
  sbwb_rsp_if rsp_if ();

  sliding_block_window_buffer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Own copy of the window state, updated as each request beat is sent.
  num_t  win_tag  [RING_DEPTH];
  logic  win_live [RING_DEPTH];
  slot_t win_head;
  cnt_t  win_occ;
  num_t  win_newest;
  logic  win_known;

  window_reply_t expected_replies[$];
  int            mismatch_count;
  int            reply_count;
  int            status_sent[5];
  int            cycle_count;
  int            send_gap_max;
  int            stall_max;

  // Clock generation.
  always #2 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d replies outstanding", cycle_count,
               expected_replies.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Drop empty slots off the head; the head stays put when the ring empties.
  function automatic void tidy_window_head();
    int n;
    for (n = 0; n < RING_DEPTH; n++) begin
      if (win_occ == 0 || win_live[win_head]) break;
      win_occ = win_occ - 1'b1;
      if (win_occ == 0) break;
      win_head = slot_t'(win_head + 1);
    end
  endfunction

  // Work out the reply to one request and advance the window state.
  function automatic window_reply_t predict_window(logic [OPC_W-1:0] op, num_t num,
                                                   logic [REL_W-1:0] rel);
    window_reply_t res;
    logic          hit;
    slot_t         s;
    slot_t         tail;
    num_t          k;
    num_t          start;
    int            i;
    res = '0;
    if (op == OP_RELEASE) begin
      if (int'(rel) < RING_DEPTH && win_live[rel]) begin
        win_live[rel] = 1'b0;
        tidy_window_head();
        res.status = ST_RELEASED;
      end else begin
        res.status = ST_IGNORED;
      end
    end else begin
      // Search the occupied region, oldest slot first.
      hit = 1'b0;
      for (i = 0; i < int'(win_occ) && !hit; i++) begin
        s = slot_t'(win_head + i);
        if (win_live[s] && win_tag[s] == num) begin
          hit = 1'b1;
          res.slot_index = s;
        end
      end
      if (hit) begin
        res.status = ST_HIT;
      end else if (win_known && num <= win_newest) begin
        res.status = ST_STALE;
      end else begin
        // Allocate the missing numbers at the tail, at most one ring's worth.
        k = win_known ? num - win_newest : num_t'(1);
        if (k > num_t'(RING_DEPTH)) k = num_t'(RING_DEPTH);
        start = num - k + num_t'(1);
        tail  = slot_t'(win_head + win_occ);
        for (i = 0; i < int'(k); i++) begin
          s = slot_t'(tail + i);
          if (win_live[s]) res.evicted = res.evicted + 1'b1;
          win_tag[s]  = start + num_t'(i);
          win_live[s] = 1'b1;
          if (win_occ >= RING_DEPTH) begin
            win_head = slot_t'(win_head + 1);
          end else begin
            win_occ = win_occ + 1'b1;
          end
          res.slot_index = s;
        end
        tidy_window_head();
        win_newest = num;
        win_known  = 1'b1;
        res.status = ST_ALLOC;
      end
    end
    return res;
  endfunction

  // A live slot chosen at random, or a random slot when none is live.
  function automatic slot_t pick_live_slot();
    int first;
    int j;
    slot_t s;
    first = $urandom_range(0, RING_DEPTH - 1);
    for (j = 0; j < RING_DEPTH; j++) begin
      s = slot_t'(first + j);
      if (win_live[s]) return s;
    end
    return slot_t'(first);
  endfunction

  // Send one request beat after a random gap and record its expected reply.
  task automatic send_request(logic [OPC_W-1:0] op, num_t num, logic [REL_W-1:0] rel);
    int            gap;
    window_reply_t res;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.opcode       <= op;
    req_if.block_number <= num;
    req_if.release_slot <= rel;
    req_if.valid        <= 1'b1;
    res = predict_window(op, num, rel);
    expected_replies.push_back(res);
    status_sent[res.status]++;
    do @(posedge clk); while (req_if.ready !== 1'b1);
  endtask

  // Stop sending and wait until every expected reply has come back.
  task automatic hold_off();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // Response side: random stalls, then compare each beat with the oldest expectation.
  initial begin : reply_checker
    window_reply_t want;
    int            stall;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, stall_max);
      @(negedge clk);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      reply_count++;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("reply with status %0d but none expected", rsp_if.status));
      end else begin
        want = expected_replies.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
        if (rsp_if.slot_index !== want.slot_index)
          report_mismatch($sformatf("slot_index %0d, expected %0d", rsp_if.slot_index,
                                    want.slot_index));
        if (rsp_if.evicted_count !== want.evicted)
          report_mismatch($sformatf("evicted_count %0d, expected %0d", rsp_if.evicted_count,
                                    want.evicted));
      end
    end
  end

  // First block only takes one slot; then empty the ring and hit a stale number.
  task automatic test_first_block();
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, '0, 4'hF);
    send_request(OP_RELEASE, NUM_MAX, '0);
    send_request(OP_RELEASE, '0, '0);
    send_request(OP_LOOKUP, '0, '0);
    hold_off();
  endtask

  // Fill the whole ring in one jump, then wrap it so the head moves.
  task automatic test_full_ring();
    send_request(OP_LOOKUP, num_t'(16), '0);
    send_request(OP_LOOKUP, num_t'(10), '0);
    send_request(OP_LOOKUP, num_t'(20), '0);
    send_request(OP_LOOKUP, num_t'(3), '0);
    hold_off();
  endtask

  // Holes inside the region, head cleanup, and jumps over holes and a full ring.
  task automatic test_holes_and_cleanup();
    slot_t hole;
    hole = slot_t'(win_head + 3);
    send_request(OP_RELEASE, '0, hole);
    send_request(OP_RELEASE, '0, hole);
    send_request(OP_RELEASE, '0, win_head);
    send_request(OP_LOOKUP, win_newest + num_t'(1), '0);
    send_request(OP_LOOKUP, win_newest + num_t'(20), '0);
    send_request(OP_LOOKUP, win_newest + num_t'(50), '0);
    hold_off();
  endtask

  // Mostly lookups near the window and releases of live slots, with idle modes changing.
  task automatic test_random_traffic(int n_items);
    int               i;
    int               pick;
    int               back;
    logic [OPC_W-1:0] op;
    num_t             num;
    logic [REL_W-1:0] rel;
    for (i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 4))
          0: begin send_gap_max = 0;  stall_max = 0;  end
          1: begin send_gap_max = 19; stall_max = 0;  end
          2: begin send_gap_max = 0;  stall_max = 19; end
          3: begin send_gap_max = 19; stall_max = 19; end
          default: begin send_gap_max = 3; stall_max = 3; end
        endcase
      end
      if (i % 300 == 150) hold_off();
      pick = $urandom_range(0, 99);
      num  = num_t'({$urandom(), $urandom()});
      rel  = REL_W'($urandom_range(0, 15));
      if (pick < 20) begin
        op  = OP_RELEASE;
        rel = pick_live_slot();
      end else if (pick < 25) begin
        op = OP_RELEASE;
      end else begin
        op = OP_LOOKUP;
        if (pick < 55) begin
          back = $urandom_range(0, 20);
          num  = (win_newest >= num_t'(back)) ? win_newest - num_t'(back) : '0;
        end else if (pick < 85) begin
          num = win_newest + num_t'($urandom_range(1, 4));
        end else if (pick < 95) begin
          num = win_newest + num_t'($urandom_range(5, 16));
        end else begin
          num = win_newest + num_t'($urandom_range(17, 2000));
        end
      end
      send_request(op, num, rel);
    end
    hold_off();
  endtask

  // Numbers at the top of the range; after this everything new is stale.
  task automatic test_top_of_range();
    send_gap_max = 5;
    stall_max    = 5;
    send_request(OP_LOOKUP, NUM_MAX - num_t'(40), '0);
    send_request(OP_LOOKUP, NUM_MAX - num_t'(30), '0);
    send_request(OP_LOOKUP, NUM_MAX - num_t'(35), '0);
    send_request(OP_RELEASE, '0, pick_live_slot());
    send_request(OP_LOOKUP, NUM_MAX, '0);
    send_request(OP_LOOKUP, NUM_MAX, '0);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, NUM_MAX - num_t'(100), '0);
    hold_off();
  endtask

  initial begin : main_sequence
    int i;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.opcode       = OP_LOOKUP;
    req_if.block_number = '0;
    req_if.release_slot = '0;
    rsp_if.ready        = 1'b0;
    mismatch_count      = 0;
    reply_count         = 0;
    cycle_count         = 0;
    for (i = 0; i < 5; i++) status_sent[i] = 0;
    for (i = 0; i < RING_DEPTH; i++) begin
      win_tag[i]  = '0;
      win_live[i] = 1'b0;
    end
    win_head     = '0;
    win_occ      = '0;
    win_newest   = '0;
    win_known    = 1'b0;
    send_gap_max = 3;
    stall_max    = 3;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_first_block();
    test_full_ring();
    test_holes_and_cleanup();
    test_random_traffic(1200);
    test_top_of_range();

    // Let any stray reply surface before deciding.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, checked %0d replies, %0d mismatches.",
             status_sent[0] + status_sent[1] + status_sent[2] + status_sent[3] + status_sent[4],
             reply_count, mismatch_count);
    $display("Hits %0d, allocations %0d, stale %0d, releases %0d, ignored releases %0d.",
             status_sent[ST_HIT], status_sent[ST_ALLOC], status_sent[ST_STALE],
             status_sent[ST_RELEASED], status_sent[ST_IGNORED]);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
